/* rtl/pcm_pkg.sv */
`default_nettype none
package pcm_pkg;

	localparam int unsigned DvdW = 48;
	localparam int unsigned DvsW = 16;
	localparam int unsigned CntW = $clog2(DvdW + 1);

	localparam logic [1:0] MODE_INVERT = 2'd0;
	localparam logic [1:0] MODE_GRAY   = 2'd1;
	localparam logic [1:0] MODE_HUE    = 2'd2;
	localparam logic [1:0] MODE_BRIGHT = 2'd3;

	typedef enum logic {
		SEL_S = 1'b0,
		SEL_H = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic     accept;
		logic     div_start;
		div_sel_t sel;
		logic     capture;
		logic     mul_c;
		logic     mul_x;
		logic     recip_a;
		logic     recip_b;
		logic     finish;
	} pcm_cmd_t;

	typedef struct packed {
		logic hue_mode;
		logic div_done;
	} pcm_status_t;

endpackage
`default_nettype wire

/* rtl/pcm_div.sv */
`default_nettype none
module pcm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pcm_pkg::DvdW-1:0]      dividend,
	input  wire logic [pcm_pkg::DvsW-1:0]      divisor,
	output logic                               done,
	output logic [pcm_pkg::DvdW-1:0]           quotient
);

	logic [pcm_pkg::DvsW:0]   rem_q;
	logic [pcm_pkg::DvdW-1:0] quo_q;
	logic [pcm_pkg::DvsW-1:0] dvs_q;
	logic [pcm_pkg::CntW-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [pcm_pkg::DvsW:0]   rem_sh;
	logic                     fits;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q[pcm_pkg::DvsW-1:0], quo_q[pcm_pkg::DvdW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pcm_pkg::CntW'(pcm_pkg::DvdW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pcm_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[pcm_pkg::DvdW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/pcm_ctrl.sv */
`default_nettype none
module pcm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire pcm_pkg::pcm_status_t status,
	output pcm_pkg::pcm_cmd_t        cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DIV_S  = 8'b0000_0010,
		ST_DIV_H  = 8'b0000_0100,
		ST_MUL_C  = 8'b0000_1000,
		ST_MUL_X  = 8'b0001_0000,
		ST_RCP_A  = 8'b0010_0000,
		ST_RCP_B  = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   issued_q;
	logic   out_valid_q;
	logic   in_div;
	logic   out_free;

	assign in_div   = state_q == ST_DIV_S || state_q == ST_DIV_H;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		cmd.sel       = pcm_pkg::SEL_S;
		state_d       = state_q;
		cmd.div_start = in_div && !issued_q;
		cmd.capture   = in_div && status.div_done;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.hue_mode ? ST_DIV_S : ST_FINISH;
				end
			end
			ST_DIV_S: begin
				cmd.sel = pcm_pkg::SEL_S;
				if (status.div_done) state_d = ST_DIV_H;
			end
			ST_DIV_H: begin
				cmd.sel = pcm_pkg::SEL_H;
				if (status.div_done) state_d = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.mul_c = 1'b1;
				state_d   = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_RCP_A;
			end
			ST_RCP_A: begin
				cmd.recip_a = 1'b1;
				state_d     = ST_RCP_B;
			end
			ST_RCP_B: begin
				cmd.recip_b = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) issued_q <= 1'b1;
			else if (status.div_done) issued_q <= 1'b0;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q != ST_IDLE)
		else $error("accept did not leave idle");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");
	a_start_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (state_q != ST_IDLE && state_q != ST_FINISH))
		else $error("divider started outside a divide step");
`endif

endmodule
`default_nettype wire

/* rtl/pcm_dp.sv */
`default_nettype none
module pcm_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_data,
	input  wire logic [31:0]          pixel_in,
	input  wire logic                 first_of_frame,
	output logic [31:0]               pixel_out,
	input  wire pcm_pkg::pcm_cmd_t    cmd,
	output pcm_pkg::pcm_status_t      status
);

	logic [1:0]  mode_q;
	logic [8:0]  off_q;
	logic [31:0] pix_q;
	logic [31:0] pixel_out_q;
	logic [16:0] s_q, h_q;
	logic [32:0] c_q, m_q, x_q;
	logic [45:0] cw_q;
	logic [41:0] t1_q;
	logic [49:0] t2_q;

	logic [7:0]  r, g, b, mx, mn, d;
	logic [16:0] v;
	logic [10:0] num;
	logic [17:0] hsum;
	logic [16:0] hp;
	logic [2:0]  sector;
	logic [16:0] sbase;
	logic [13:0] f, w;
	logic [47:0] dvd;
	logic [15:0] dvs;
	logic        div_done;
	logic [47:0] quo;
	logic [36:0] z;
	logic [41:0] t1;
	logic [49:0] t2;
	logic [73:0] qsum;
	logic [32:0] cr, cg, cb;
	logic [15:0] gray_sum;
	logic [8:0]  rb, gb, bb;
	logic [23:0] rgb;

	assign r = pix_q[23:16];
	assign g = pix_q[15:8];
	assign b = pix_q[7:0];

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end
	assign d = mx - mn;

	// ceil(mx * 65536 / 255) is mx * 257, plus one unless mx is zero
	assign v = {1'b0, mx, mx} + 17'(mx != 8'd0);

	always_comb begin
		if (mx == r)
			num = (g >= b) ? 11'(g - b) : 11'(11'(d) * 11'd6 - 11'(b - g));
		else if (mx == g)
			num = 11'(11'(d) * 11'd2 + 11'(b) - 11'(r));
		else
			num = 11'(11'(d) * 11'd4 + 11'(r) - 11'(g));
	end

	always_comb begin
		unique case (cmd.sel)
			pcm_pkg::SEL_S: begin
				dvd = {24'd0, d, 16'd0} + 48'(mx) - 48'd1;
				dvs = 16'(mx);
			end
			pcm_pkg::SEL_H: begin
				dvd = (d == 8'd0) ? 48'd0 : 48'(num) * 48'd15360;
				dvs = (d == 8'd0) ? 16'd1 : 16'(d);
			end
		endcase
	end

	pcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	// rotated hue and its sector
	assign hsum = 18'(h_q) + {1'b0, off_q, 8'd0};
	assign hp   = (hsum >= 18'd92160) ? 17'(hsum - 18'd92160) : hsum[16:0];

	always_comb begin
		if (hp >= 17'd76800)      sector = 3'd5;
		else if (hp >= 17'd61440) sector = 3'd4;
		else if (hp >= 17'd46080) sector = 3'd3;
		else if (hp >= 17'd30720) sector = 3'd2;
		else if (hp >= 17'd15360) sector = 3'd1;
		else                      sector = 3'd0;
	end
	assign sbase = 17'(sector) * 17'd15360;
	assign f     = 14'(hp - sbase);
	assign w     = sector[0] ? 14'(14'd15360 - f) : f;

	// x = c*w / 15360 = (c*w >> 10) / 15; the divide by 15 is
	// ((y + 1) * 0x1111111111) >> 40, built from shifted sums over two steps
	assign z    = 37'(cw_q >> 10) + 37'd1;
	assign t1   = 42'(z) + 42'({z, 4'd0});
	assign t2   = 50'(t1) + 50'({t1, 8'd0});
	assign qsum = {t2_q, 24'd0} + 74'({t2_q, 8'd0}) + 74'(t1_q);

	always_comb begin
		unique case (sector)
			3'd0: begin cr = c_q; cg = x_q; cb = '0;  end
			3'd1: begin cr = x_q; cg = c_q; cb = '0;  end
			3'd2: begin cr = '0;  cg = c_q; cb = x_q; end
			3'd3: begin cr = '0;  cg = x_q; cb = c_q; end
			3'd4: begin cr = x_q; cg = '0;  cb = c_q; end
			default: begin cr = c_q; cg = '0; cb = x_q; end
		endcase
	end

	function automatic logic [7:0] to_chan(input logic [32:0] comp, input logic [32:0] m);
		logic [32:0] sum;
		logic [40:0] prod;
		sum  = comp + m;
		prod = {sum, 8'd0} - 41'(sum);
		return (prod[40]) ? 8'd255 : prod[39:32];
	endfunction

	assign gray_sum = 16'(r) * 16'd77 + 16'(g) * 16'd150 + 16'(b) * 16'd29;
	assign rb = 9'(r) + 9'd8;
	assign gb = 9'(g) + 9'd8;
	assign bb = 9'(b) + 9'd8;

	always_comb begin
		unique case (mode_q)
			pcm_pkg::MODE_INVERT: rgb = ~pix_q[23:0];
			pcm_pkg::MODE_GRAY:   rgb = {3{gray_sum[15:8]}};
			pcm_pkg::MODE_HUE: begin
				if (mx == 8'd0) rgb = '0;
				else rgb = {to_chan(cr, m_q), to_chan(cg, m_q), to_chan(cb, m_q)};
			end
			default: rgb = {rb[8] ? 8'd255 : rb[7:0],
			                gb[8] ? 8'd255 : gb[7:0],
			                bb[8] ? 8'd255 : bb[7:0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pcm_pkg::MODE_INVERT;
			off_q  <= '0;
		end else begin
			if (cfg_we) mode_q <= cfg_data;
			// hue offset steps 3 degrees at each frame start in hue mode
			if (cmd.accept && mode_q == pcm_pkg::MODE_HUE && first_of_frame)
				off_q <= (off_q >= 9'd357) ? 9'd0 : 9'(off_q + 9'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) pix_q <= pixel_in;
		if (cmd.capture) begin
			unique case (cmd.sel)
				pcm_pkg::SEL_S: s_q <= quo[16:0];
				pcm_pkg::SEL_H: h_q <= quo[16:0];
			endcase
		end
		if (cmd.mul_c) c_q <= 33'(v) * 33'(s_q);
		if (cmd.mul_x) begin
			cw_q <= 46'(c_q) * 46'(w);
			m_q  <= {v, 16'd0} - c_q;
		end
		if (cmd.recip_a) begin
			t1_q <= t1;
			t2_q <= t2;
		end
		if (cmd.recip_b) x_q <= 33'(qsum >> 40);
		if (cmd.finish) pixel_out_q <= {pix_q[31:24], rgb};
	end

	assign pixel_out         = pixel_out_q;
	assign status.hue_mode   = mode_q == pcm_pkg::MODE_HUE;
	assign status.div_done   = div_done;

endmodule
`default_nettype wire

/* rtl/pixel_color_modifier.sv */
`default_nettype none
// Per-pixel ARGB color effect; alpha always passes. One pixel is in work at a
// time. Invert, grayscale and brightness go from the input transfer straight
// to the finish step, which registers the result. Hue shift runs two
// 48-step divisions (saturation, hue) on one shared restoring divider, each
// with start and done, then two multiply and two reciprocal steps before the
// finish step. An output stall holds the finish step back. cfg_data is
// written at any edge with cfg_we high and must only change while idle.
module pixel_color_modifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pixel_in,
	input  wire logic        first_of_frame,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_out
);

	pcm_pkg::pcm_cmd_t    cmd;
	pcm_pkg::pcm_status_t status;

	pcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pcm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.pixel_in       (pixel_in),
		.first_of_frame (first_of_frame),
		.pixel_out      (pixel_out),
		.cmd            (cmd),
		.status         (status)
	);

endmodule
`default_nettype wire
